[rtl/ptc_pkg.sv]
// Package with CORDIC constants, types and helpers for the pan-tilt transform.
package ptc_pkg;

  localparam int CordicSteps = 30;
  localparam int CordicW     = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  typedef enum logic [1:0] {
    REG_BASE_X = 2'd0,
    REG_BASE_Z = 2'd1,
    REG_LINK_A = 2'd2,
    REG_LINK_B = 2'd3
  } reg_idx_t;

  typedef logic signed [CordicW-1:0] cval_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
        3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
        6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
        9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
        12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41721;
        15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
        18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
        21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
        24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
        27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
        default: t = 32'd0;
      endcase
      return t;
    end
  endfunction

endpackage

[rtl/ptc_cordic.sv]
// Pipelined CORDIC that gives quadrant-mapped cosine and sine of a binary angle.
module ptc_cordic #(
  parameter int ANGLE_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16,
  parameter int STEPS_PER_STG  = 3
) (
  input  logic                            clk,
  input  logic [ANGLE_WIDTH-1:0]          angle,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_out,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_out
);

  localparam int W      = ptc_pkg::CordicW;
  localparam int NSTEP  = ptc_pkg::CordicSteps;
  localparam int NSTG   = (NSTEP + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int SH     = 30 - TRIG_FRAC_BITS;
  localparam int TW     = TRIG_FRAC_BITS + 2;

  logic signed [W-1:0] x_r [NSTG+1];
  logic signed [W-1:0] y_r [NSTG+1];
  logic signed [W-1:0] z_r [NSTG+1];
  logic [1:0]          q_r [NSTG+2];
  logic signed [TW-1:0] c0_r, s0_r;

  logic [31:0] phase;
  assign phase = 32'(angle) << (32 - ANGLE_WIDTH);

  always_ff @(posedge clk) begin
    x_r[0] <= ptc_pkg::CordicGain;
    y_r[0] <= '0;
    z_r[0] <= W'({2'b00, phase[29:0]});
    q_r[0] <= phase[31:30];
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic signed [W-1:0] xs, ys, zs;
    always_comb begin
      xs = x_r[g];
      ys = y_r[g];
      zs = z_r[g];
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        logic signed [W-1:0] dx, dy, xo;
        dx = ys >>> (g * STEPS_PER_STG + k);
        dy = xs >>> (g * STEPS_PER_STG + k);
        xo = xs;
        if (g * STEPS_PER_STG + k < NSTEP) begin
          if (!zs[W-1]) begin
            xs = xo - dx;
            ys = ys + dy;
            zs = zs - W'(ptc_pkg::atan_entry(g * STEPS_PER_STG + k));
          end else begin
            xs = xo + dx;
            ys = ys - dy;
            zs = zs + W'(ptc_pkg::atan_entry(g * STEPS_PER_STG + k));
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      x_r[g+1] <= xs;
      y_r[g+1] <= ys;
      z_r[g+1] <= zs;
      q_r[g+1] <= q_r[g];
    end
  end

  function automatic logic signed [TW-1:0] rnd_clamp(input logic signed [W-1:0] v);
    logic signed [W:0] t;
    logic signed [W:0] one;
    begin
      t   = ((W+1)'(v) + ((W+1)'(1) << SH - 1)) >>> SH;
      one = (W+1)'(1) << TRIG_FRAC_BITS;
      if (t > one) t = one;
      if (t < -one) t = -one;
      return TW'(t);
    end
  endfunction

  always_ff @(posedge clk) begin
    c0_r       <= rnd_clamp(x_r[NSTG]);
    s0_r       <= rnd_clamp(y_r[NSTG]);
    q_r[NSTG+1] <= q_r[NSTG];
  end

  always_comb begin
    case (q_r[NSTG+1])
      2'd0: begin cos_out = c0_r;  sin_out = s0_r;  end
      2'd1: begin cos_out = -s0_r; sin_out = c0_r;  end
      2'd2: begin cos_out = -c0_r; sin_out = -s0_r; end
      default: begin cos_out = s0_r; sin_out = -c0_r; end
    endcase
  end

endmodule

[rtl/pan_tilt_camera_to_base_transform_unit.sv]
// Top level of the pan-tilt camera-to-base coordinate transform.
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------------------
//  input    start / busy            in_cam_x/y/z, in_yaw_angle, in_pitch_angle
//  result   out_valid (strobe)      out_base_x/y/z, out_saturated
//  config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A new point may start every cycle; busy stays low. Each point emerges
// after fifteen register stages, counting the edge that accepted it: the
// CORDIC pipeline (one input register, ten stages of three rotations, one
// rounding register) followed by three arithmetic stages. The valid bit
// travels alongside the data, so nothing is lost or repeated. Reset (rst_n
// low at a clock edge) clears the valid bits and restores the register
// defaults. The receiver cannot stall the result.
module pan_tilt_camera_to_base_transform_unit #(
  parameter int COORD_WIDTH    = 24,
  parameter int ANGLE_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_cam_x,
  input  logic signed [COORD_WIDTH-1:0] in_cam_y,
  input  logic signed [COORD_WIDTH-1:0] in_cam_z,
  input  logic [ANGLE_WIDTH-1:0]        in_yaw_angle,
  input  logic [ANGLE_WIDTH-1:0]        in_pitch_angle,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_base_x,
  output logic signed [COORD_WIDTH-1:0] out_base_y,
  output logic signed [COORD_WIDTH-1:0] out_base_z,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);

  localparam int SPS   = 3;
  localparam int NSTG  = (ptc_pkg::CordicSteps + SPS - 1) / SPS;
  localparam int TLAT  = NSTG + 2;           // registers from angle to trig
  localparam int TW    = TRIG_FRAC_BITS + 2;
  localparam int F     = TRIG_FRAC_BITS;
  localparam int PW    = COORD_WIDTH + TW + 4; // product and sum width
  localparam int RW    = PW - F + 1;           // rounded width
  localparam int DLY   = TLAT;

  logic [15:0] bxo_r, bzo_r, la_r, lb_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Register file; all four indexes are decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bxo_r <= 16'd724;
      bzo_r <= 16'd3632;
      la_r  <= 16'd833;
      lb_r  <= 16'd848;
    end else if (cfg_valid) begin
      unique case (ptc_pkg::reg_idx_t'(cfg_index))
        ptc_pkg::REG_BASE_X: bxo_r <= cfg_data;
        ptc_pkg::REG_BASE_Z: bzo_r <= cfg_data;
        ptc_pkg::REG_LINK_A: la_r  <= cfg_data;
        ptc_pkg::REG_LINK_B: lb_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [TW-1:0] cy, sy, cp, sp;

  ptc_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
               .STEPS_PER_STG(SPS)) u_yaw (
    .clk(clk), .angle(in_yaw_angle), .cos_out(cy), .sin_out(sy));

  ptc_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
               .STEPS_PER_STG(SPS)) u_pitch (
    .clk(clk), .angle(in_pitch_angle), .cos_out(cp), .sin_out(sp));

  // Point delay line that matches the trig latency.
  logic signed [COORD_WIDTH-1:0] px_r [DLY], py_r [DLY], pz_r [DLY];
  logic [DLY-1:0] vd_r;

  always_ff @(posedge clk) begin
    px_r[0] <= in_cam_x;
    py_r[0] <= in_cam_y;
    pz_r[0] <= in_cam_z;
    for (int i = 1; i < DLY; i++) begin
      px_r[i] <= px_r[i-1];
      py_r[i] <= py_r[i-1];
      pz_r[i] <= pz_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else        vd_r <= {vd_r[DLY-2:0], start};
  end

  function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    begin
      t = (v + (PW'(1) <<< (F - 1))) >>> F;
      return RW'(t);
    end
  endfunction

  // Stage A: pitch rotation products and pitch link terms.
  logic signed [PW-1:0] a_x1_r, a_z_r, a_lx_r, a_lz_r;
  logic signed [COORD_WIDTH-1:0] a_y_r;
  logic signed [TW-1:0] a_cy_r, a_sy_r;
  logic a_v_r;

  always_ff @(posedge clk) begin
    a_x1_r <= PW'(cp * px_r[DLY-1]) + PW'(sp * pz_r[DLY-1]);
    a_z_r  <= PW'(cp * pz_r[DLY-1]) - PW'(sp * px_r[DLY-1]) + PW'(cp * $signed({1'b0, lb_r}));
    a_lx_r <= PW'(cp * $signed({1'b0, la_r})) + PW'(sp * $signed({1'b0, lb_r}));
    a_lz_r <= '0;
    a_y_r  <= py_r[DLY-1];
    a_cy_r <= cy;
    a_sy_r <= sy;
  end

  // Stage B: round x1, rotate about z; round z and add the z offset.
  logic signed [RW-1:0] x1;
  assign x1 = rnd(a_x1_r);

  logic signed [PW-1:0] b_x_r, b_y_r;
  logic signed [RW-1:0] b_z_r;

  always_ff @(posedge clk) begin
    b_x_r <= PW'(a_cy_r * x1) - PW'(a_sy_r * a_y_r) + a_lx_r + a_lz_r;
    b_y_r <= PW'(a_sy_r * x1) + PW'(a_cy_r * a_y_r);
    b_z_r <= rnd(a_z_r) + RW'(bzo_r);
  end

  // Stage C: round, offset and saturate.
  function automatic logic signed [COORD_WIDTH-1:0] satv(
      input logic signed [RW:0] v, output logic hit);
    logic signed [RW:0] hi, lo;
    begin
      hi  = (RW+1)'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
      lo  = -(RW+1)'(64'sd1 <<< (COORD_WIDTH - 1));
      hit = (v > hi) || (v < lo);
      if (v > hi)      return COORD_WIDTH'(hi);
      else if (v < lo) return COORD_WIDTH'(lo);
      else             return COORD_WIDTH'(v);
    end
  endfunction

  logic signed [COORD_WIDTH-1:0] sx, sy_o, sz;
  logic hx, hy, hz;

  always_comb begin
    sx   = satv((RW+1)'(rnd(b_x_r)) + (RW+1)'(bxo_r), hx);
    sy_o = satv((RW+1)'(rnd(b_y_r)), hy);
    sz   = satv((RW+1)'(b_z_r), hz);
  end

  logic a_vv_r, b_v_r, c_v_r;
  assign a_v_r = vd_r[DLY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vv_r <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
    end else begin
      a_vv_r <= a_v_r;
      b_v_r  <= a_vv_r;
      c_v_r  <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_base_x    <= sx;
    out_base_y    <= sy_o;
    out_base_z    <= sz;
    out_saturated <= hx | hy | hz;
  end

  assign out_valid = c_v_r;

  // A result strobe always follows a valid bit leaving the point delay line, through stages A, B and C.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[DLY-1] |=> ##2 out_valid)
    else $error("result strobe missing");
  a_nobusy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("strobe after reset");

endmodule

[sim/pan_tilt_transform_checker.sv]
// Checker that predicts and compares the base-frame points of the pan-tilt transform.
module pan_tilt_transform_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] in_cam_x,
  input  logic signed [23:0] in_cam_y,
  input  logic signed [23:0] in_cam_z,
  input  logic [15:0]        in_yaw_angle,
  input  logic [15:0]        in_pitch_angle,
  input  logic               out_valid,
  input  logic signed [23:0] out_base_x,
  input  logic signed [23:0] out_base_y,
  input  logic signed [23:0] out_base_z,
  input  logic               out_saturated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 points_waiting,
  output int                 points_checked,
  output int                 clipped_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [23:0] bz;
    logic               sat;
  } base_point_t;

  localparam longint ArcTan[30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41721, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  base_point_t base_points_due[$];
  logic [15:0] x_offset, z_offset, link_a, link_b;

  function automatic longint clip_unit(input longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // Rotation-mode CORDIC over the first quadrant, then folded out by quadrant.
  task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] phase;
    longint cx, cy, cz, dx, dy, qc, qs;
    phase = {ang, 16'h0000};
    cx = 652032874;
    cy = 0;
    cz = longint'(phase[29:0]);
    for (int i = 0; i < 30; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= ArcTan[i];
      end else begin
        cx += dx; cy -= dy; cz += ArcTan[i];
      end
    end
    qc = clip_unit((cx + 64'sd8192) >>> 14);
    qs = clip_unit((cy + 64'sd8192) >>> 14);
    case (phase[31:30])
      2'd0: begin c = qc;  s = qs;  end
      2'd1: begin c = -qs; s = qc;  end
      2'd2: begin c = -qc; s = -qs; end
      default: begin c = qs; s = -qc; end
    endcase
  endtask

  function automatic longint round16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] clip_coord(input longint v, inout logic hit);
    if (v > 64'sd8388607) begin hit = 1'b1; return 24'sh7FFFFF; end
    if (v < -64'sd8388608) begin hit = 1'b1; return 24'sh800000; end
    return v[23:0];
  endfunction

  task automatic transform_point(output base_point_t p);
    longint cy, sy, cp, sp, x, y, z, x1;
    logic hit;
    hit = 1'b0;
    x = in_cam_x;
    y = in_cam_y;
    z = in_cam_z;
    sin_cos(in_yaw_angle, cy, sy);
    sin_cos(in_pitch_angle, cp, sp);
    x1 = round16(cp * x + sp * z);
    p.bx = clip_coord(round16(cy * x1 - sy * y + longint'(link_a) * cp
                             + longint'(link_b) * sp) + longint'(x_offset), hit);
    p.by = clip_coord(round16(sy * x1 + cy * y), hit);
    p.bz = clip_coord(round16(cp * z - sp * x + longint'(link_b) * cp)
                      + longint'(z_offset), hit);
    p.sat = hit;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    points_waiting = 0;
    points_checked = 0;
    clipped_seen = 0;
  end

  always @(posedge clk) begin
    base_point_t p;
    if (!rst_n) begin
      x_offset <= 16'd724;
      z_offset <= 16'd3632;
      link_a   <= 16'd833;
      link_b   <= 16'd848;
      base_points_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (ptc_pkg::reg_idx_t'(cfg_index))
          ptc_pkg::REG_BASE_X: x_offset <= cfg_data;
          ptc_pkg::REG_BASE_Z: z_offset <= cfg_data;
          ptc_pkg::REG_LINK_A: link_a   <= cfg_data;
          ptc_pkg::REG_LINK_B: link_b   <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        transform_point(p);
        base_points_due.push_back(p);
      end
      if (out_valid) begin
        if (base_points_due.size() == 0) begin
          report_mismatch("unexpected result", out_base_x, 0);
        end else begin
          p = base_points_due.pop_front();
          points_checked++;
          if (p.sat) clipped_seen++;
          if (out_base_x !== p.bx) report_mismatch("base_x", out_base_x, p.bx);
          if (out_base_y !== p.by) report_mismatch("base_y", out_base_y, p.by);
          if (out_base_z !== p.bz) report_mismatch("base_z", out_base_z, p.bz);
          if (out_saturated !== p.sat) report_mismatch("saturated", out_saturated, p.sat);
        end
      end
    end
    points_waiting = base_points_due.size();
  end
endmodule

[sim/pan_tilt_camera_to_base_transform_unit_tb.sv]
// Testbench top: drives points and register writes into the pan-tilt transform.
module pan_tilt_camera_to_base_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The pipeline is about fifteen stages deep; this margin covers it well.
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] in_cam_x = '0, in_cam_y = '0, in_cam_z = '0;
  logic [15:0]        in_yaw_angle = '0, in_pitch_angle = '0;
  logic               out_valid, out_saturated;
  logic signed [23:0] out_base_x, out_base_y, out_base_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int  fail_count, points_waiting, points_checked, clipped_seen;
  int  cycle_count = 0;
  int  points_sent = 0;
  bit  no_idle = 1'b0;

  pan_tilt_camera_to_base_transform_unit u_dut (.*);

  pan_tilt_transform_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one point and hold it until a transfer happens. Afterwards the
  // sender draws an idle gap; with no gap the strobe simply stays high and the
  // next point replaces the fields at the following falling edge.
  task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                            input logic signed [23:0] z, input logic [15:0] yaw,
                            input logic [15:0] pitch);
    int gap;
    @(negedge clk);
    start          <= 1'b1;
    in_cam_x       <= x;
    in_cam_y       <= y;
    in_cam_z       <= z;
    in_yaw_angle   <= yaw;
    in_pitch_angle <= pitch;
    do @(posedge clk); while (busy);
    points_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Let the pipeline empty out completely before anything else happens.
  task automatic wait_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (points_waiting != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register writes happen only once the block has gone idle.
  task automatic write_register(input ptc_pkg::reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_geometry(input logic [15:0] xo, input logic [15:0] zo,
                               input logic [15:0] la, input logic [15:0] lb);
    wait_until_drained();
    write_register(ptc_pkg::REG_BASE_X, xo);
    write_register(ptc_pkg::REG_BASE_Z, zo);
    write_register(ptc_pkg::REG_LINK_A, la);
    write_register(ptc_pkg::REG_LINK_B, lb);
  endtask

  // Mostly full-range coordinates, with a share of small ones (realistic
  // distances) and some right at the rails so that clipping shows up.
  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'(24'sh7FFFFF - $urandom_range(0, 300))
                                     : 24'(24'sh800000 + $urandom_range(0, 300));
      1, 2, 3: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 7) == 0)
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 4) - 2);
    return 16'($urandom);
  endfunction

  task automatic random_points(input int count);
    for (int i = 0; i < count; i++) begin
      // Alternate stretches of back-to-back points with idled ones.
      if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_point(pick_coord(), pick_coord(), pick_coord(), pick_angle(), pick_angle());
      // Once per phase, the sender holds off until every result has arrived.
      if (i == count / 2) wait_until_drained();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    logic signed [23:0] cmax, cmin;
    cmax = 24'sh7FFFFF;
    cmin = 24'sh800000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed points with the reset geometry: zero point, the quarter turns,
    // the top of the angle range, and coordinates at both rails (the latter
    // force clipping on rotated axes).
    send_point(0, 0, 0, 16'd0, 16'd0);
    send_point(1000, -2000, 3000, 16'd16384, 16'd0);
    send_point(1000, -2000, 3000, 16'd32768, 16'd16384);
    send_point(1000, -2000, 3000, 16'd49152, 16'd32768);
    send_point(1000, -2000, 3000, 16'd0, 16'd49152);
    send_point(-1, 1, -1, 16'hFFFF, 16'hFFFF);
    send_point(cmax, cmax, cmax, 16'd0, 16'd0);
    send_point(cmin, cmin, cmin, 16'd0, 16'd0);
    send_point(cmax, cmax, cmax, 16'd8192, 16'd8192);
    send_point(cmin, cmax, cmin, 16'd8192, 16'd57344);
    send_point(cmax, cmin, cmax, 16'd40960, 16'd24576);
    send_point(cmax, 0, cmin, 16'd0, 16'd8192);
    send_point(0, cmax, 0, 16'd16384, 16'd0);
    send_point(0, cmin, 0, 16'd49152, 16'd0);
    send_point(12345, 6789, -4321, 16'd1, 16'd65534);
    send_point(-8000000, 8000000, 4000000, 16'hAAAA, 16'h5555);

    // Random phases, each under its own link geometry, the extremes included.
    random_points(260);
    load_geometry(16'd0, 16'd0, 16'd0, 16'd0);
    send_point(cmax, 0, 0, 16'd0, 16'd0);
    send_point(cmin, 0, 0, 16'd0, 16'd0);
    random_points(260);
    load_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(cmax, 0, cmax, 16'd0, 16'd0);
    random_points(260);
    load_geometry(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_points(260);
    load_geometry(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    random_points(260);

    wait_until_drained();
    $display("Covered %0d points under five register settings, %0d results checked,",
             points_sent, points_checked);
    $display("%0d of them clipped; back-to-back and idled transfers mixed.", clipped_seen);
    if (fail_count == 0 && points_waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", fail_count, points_waiting);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[pan_tilt_camera_to_base_transform_unit.f]
rtl/ptc_pkg.sv
rtl/ptc_cordic.sv
rtl/pan_tilt_camera_to_base_transform_unit.sv
sim/pan_tilt_transform_checker.sv
sim/pan_tilt_camera_to_base_transform_unit_tb.sv
